@@ rtl/lwc_pkg.sv @@
// ----------------------------------------------------------------------------
// lwc_pkg
// shared types and constants of the lru write-back cache
// ----------------------------------------------------------------------------
package lwc_pkg;

  localparam int LINES_DEF     = 16;
  localparam int KEY_BITS_DEF  = 32;
  localparam int DATA_BITS_DEF = 64;

  localparam int MODE_W = 2;
  localparam int CFG_W  = 5;
  localparam logic [CFG_W-1:0] CFG_ENTRIES_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // outcome of one lookup, handed from the line array to the datapath
  typedef struct packed {
    logic hit;       // key present, not a no-op
    logic fetch;     // read miss
    logic evict;     // insert into a full cache
    logic wb;        // evicted line was dirty
    logic ram_we;    // data word written
    logic ram_re;    // data word read (read hit or write-back)
    logic rd_hit;    // read hit, data goes out as read data
  } lwc_lookup_t;

endpackage

@@ rtl/lwc_data_ram.sv @@
// ----------------------------------------------------------------------------
// lwc_data_ram
// data word store, one write and one registered read port
// ----------------------------------------------------------------------------
module lwc_data_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lwc_lines.sv @@
// ----------------------------------------------------------------------------
// lwc_lines
// line tags, valid, dirty and age; parallel lookup and lru update
// ----------------------------------------------------------------------------
module lwc_lines #(
  parameter int LINES    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_en,
  input  logic [lwc_pkg::MODE_W-1:0] mode,
  input  logic [KEY_BITS-1:0]      key,
  input  logic [lwc_pkg::CFG_W-1:0]  cfg_entries,
  output lwc_pkg::lwc_lookup_t     lkp,
  output logic [$clog2(LINES)-1:0] rd_idx,
  output logic [$clog2(LINES)-1:0] wr_idx,
  output logic [KEY_BITS-1:0]      wb_key
);

  import lwc_pkg::*;

  localparam int IDX_W = $clog2(LINES);
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(LINES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [LINES-1:0]    valid_r, valid_nxt;
  logic [LINES-1:0]    dirty_r, dirty_nxt;
  logic [AGE_W-1:0]    age_r   [LINES];
  logic [AGE_W-1:0]    age_nxt [LINES];
  logic [KEY_BITS-1:0] key_r   [LINES];
  logic [CNT_W-1:0]    count_r, count_nxt;

  mode_t            m;
  logic [LINES-1:0] match;
  logic [IDX_W-1:0] found_idx, free_idx, victim_idx;
  logic [AGE_W-1:0] found_age, oldest_age;
  logic [CMP_W-1:0] cfg_w, lines_w, limit_w, count_w;
  logic             any_hit, insert, full, is_rw;

  assign m     = mode_t'(mode);
  assign is_rw = (m == MODE_WRITE) || (m == MODE_FILL);

  // clamp the line limit to 1 .. LINES
  always_comb begin
    cfg_w   = CMP_W'(cfg_entries);
    lines_w = CMP_W'(LINES);
    count_w = CMP_W'(count_r);
    if (cfg_w == '0) begin
      limit_w = CMP_W'(1);
    end else if (cfg_w > lines_w) begin
      limit_w = lines_w;
    end else begin
      limit_w = cfg_w;
    end
    full = (count_w >= limit_w);
  end

  // valid lines hold distinct ages 0 .. count-1, so the oldest has count-1
  assign oldest_age = AGE_W'(count_r - CNT_W'(1));

  always_comb begin
    found_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int j = LINES - 1; j >= 0; j--) begin
      match[j] = valid_r[j] && (key_r[j] == key);
      if (match[j]) begin
        found_idx = IDX_W'(j);
      end
      if (!valid_r[j]) begin
        free_idx = IDX_W'(j);
      end
      if (valid_r[j] && (age_r[j] == oldest_age)) begin
        victim_idx = IDX_W'(j);
      end
    end
  end

  assign any_hit   = (|match) && (m != MODE_NOP);
  assign insert    = !(|match) && is_rw;
  assign found_age = age_r[found_idx];

  always_comb begin
    lkp.hit    = any_hit;
    lkp.fetch  = !(|match) && (m == MODE_READ);
    lkp.evict  = insert && full;
    lkp.wb     = insert && full && dirty_r[victim_idx];
    lkp.ram_we = insert || (any_hit && (m == MODE_WRITE));
    lkp.rd_hit = any_hit && (m == MODE_READ);
    lkp.ram_re = lkp.rd_hit || lkp.wb;
  end

  assign rd_idx = any_hit ? found_idx : victim_idx;
  assign wr_idx = any_hit ? found_idx : (full ? victim_idx : free_idx);
  assign wb_key = key_r[victim_idx];

  // lru update
  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    count_nxt = count_r;
    for (int j = 0; j < LINES; j++) begin
      age_nxt[j] = age_r[j];
    end
    if (item_en && any_hit) begin
      for (int j = 0; j < LINES; j++) begin
        if (valid_r[j] && (age_r[j] < found_age)) begin
          age_nxt[j] = age_r[j] + AGE_W'(1);
        end
      end
      age_nxt[found_idx] = '0;
      if (m == MODE_WRITE) begin
        dirty_nxt[found_idx] = 1'b1;
      end
    end else if (item_en && insert) begin
      for (int j = 0; j < LINES; j++) begin
        if (valid_r[j]) begin
          age_nxt[j] = age_r[j] + AGE_W'(1);
        end
      end
      age_nxt[wr_idx]   = '0;
      valid_nxt[wr_idx] = 1'b1;
      dirty_nxt[wr_idx] = (m == MODE_WRITE);
      if (!full) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      count_r <= '0;
      for (int j = 0; j < LINES; j++) begin
        age_r[j] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      count_r <= count_nxt;
      for (int j = 0; j < LINES; j++) begin
        age_r[j] <= age_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_en && insert) begin
      key_r[wr_idx] <= key;
    end
  end

endmodule

@@ rtl/lru_writeback_cache.sv @@
// ----------------------------------------------------------------------------
// lru_writeback_cache
// fully associative write-back cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one access word per handshake; in_tuser is the mode (read,
//           write, fill, no-op), in_tdata carries key and write data
//   out_* : one result word per access; out_tuser carries the hit,
//           fetch-needed and write-back flags, out_tdata the read data and
//           the evicted dirty line (key and data)
//   cfg_* : line limit, written while no access is in flight
// timing:
//   an access is registered in the input register, looked up against all
//   lines in parallel and its result lands in the output register, which
//   drives out_tvalid; one access is taken per cycle while out_tready is high.
//   the line array compare and age update, plus the single data ram read
//   port (read hit or victim), lie between those two registers.
// reset:
//   all lines invalid and clean, ages zero, line limit back to 16; the data
//   ram is not cleared, no word is read before it is written
// stall:
//   while out_tready is low the result holds, one more access waits in the
//   input register and then in_tready drops
// ----------------------------------------------------------------------------
module lru_writeback_cache #(
  parameter int LINES     = lwc_pkg::LINES_DEF,
  parameter int KEY_BITS  = lwc_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = lwc_pkg::DATA_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // key, write_data
  input  logic [((KEY_BITS+DATA_BITS+7)/8)*8-1:0] in_tdata,
  // mode
  input  logic [lwc_pkg::MODE_W-1:0]     in_tuser,
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // read_data, writeback_key, writeback_data
  output logic [((2*DATA_BITS+KEY_BITS+7)/8)*8-1:0] out_tdata,
  // hit, fetch_needed, writeback_valid
  output logic [2:0]                     out_tuser,
  // configuration: entries_in_use
  input  logic                           cfg_wr_en,
  input  logic [lwc_pkg::CFG_W-1:0]      cfg_wr_data
);

  import lwc_pkg::*;

  localparam int IDX_W = $clog2(LINES);

  // input register
  logic                 s1_valid_r;
  logic [MODE_W-1:0]    s1_mode_r;
  logic [KEY_BITS-1:0]  s1_key_r;
  logic [DATA_BITS-1:0] s1_data_r;

  // output register
  logic                 out_valid_r;
  logic                 out_hit_r, out_fetch_r, out_wb_r, out_rd_r;
  logic [KEY_BITS-1:0]  out_wb_key_r;

  logic [CFG_W-1:0]     cfg_entries_r;

  logic                 advance, item_en, in_acc;
  lwc_lookup_t          lkp;
  logic [IDX_W-1:0]     rd_idx, wr_idx;
  logic [KEY_BITS-1:0]  wb_key;
  logic [DATA_BITS-1:0] ram_q;

  assign advance   = !out_valid_r || out_tready;
  assign item_en   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // line limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= CFG_ENTRIES_RESET;
    end else if (cfg_wr_en) begin
      cfg_entries_r <= cfg_wr_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_tuser;
      s1_key_r  <= in_tdata[KEY_BITS-1:0];
      s1_data_r <= in_tdata[KEY_BITS+DATA_BITS-1:KEY_BITS];
    end
  end

  // tags, valid, dirty and lru ages
  lwc_lines #(
    .LINES    (LINES),
    .KEY_BITS (KEY_BITS)
  ) u_lines (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (item_en),
    .mode        (s1_mode_r),
    .key         (s1_key_r),
    .cfg_entries (cfg_entries_r),
    .lkp         (lkp),
    .rd_idx      (rd_idx),
    .wr_idx      (wr_idx),
    .wb_key      (wb_key)
  );

  // data words; the read lands together with the output register
  lwc_data_ram #(
    .DEPTH (LINES),
    .WIDTH (DATA_BITS)
  ) u_data_ram (
    .clk   (clk),
    .we    (item_en && lkp.ram_we),
    .waddr (wr_idx),
    .wdata (s1_data_r),
    .re    (item_en && lkp.ram_re),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_en) begin
      out_hit_r    <= lkp.hit;
      out_fetch_r  <= lkp.fetch;
      out_wb_r     <= lkp.wb;
      out_rd_r     <= lkp.rd_hit;
      out_wb_key_r <= lkp.wb ? wb_key : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_wb_r, out_fetch_r, out_hit_r};

  always_comb begin
    out_tdata = '0;
    out_tdata[DATA_BITS-1:0] = out_rd_r ? ram_q : '0;
    out_tdata[DATA_BITS+KEY_BITS-1:DATA_BITS] = out_wb_key_r;
    out_tdata[2*DATA_BITS+KEY_BITS-1:DATA_BITS+KEY_BITS] = out_wb_r ? ram_q : '0;
  end

endmodule

@@ rtl/lwc_checker.sv @@
// ----------------------------------------------------------------------------
// lwc_checker
// port-level checks of the lru write-back cache, bound to the top level
// ----------------------------------------------------------------------------
module lwc_checker #(
  parameter int KEY_BITS  = lwc_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = lwc_pkg::DATA_BITS_DEF
) (
  input logic                                     clk,
  input logic                                     rst_n,
  input logic                                     out_tvalid,
  input logic                                     out_tready,
  input logic [((2*DATA_BITS+KEY_BITS+7)/8)*8-1:0] out_tdata,
  input logic [2:0]                               out_tuser
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no result right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a hit never asks for a fetch nor evicts
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1] && !out_tuser[2])
    else $error("hit with fetch or write-back");

  // read data only on a hit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[DATA_BITS-1:0] == '0)
    else $error("read data without hit");

  // write-back fields zero unless a dirty line went out
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |->
      out_tdata[2*DATA_BITS+KEY_BITS-1:DATA_BITS] == '0)
    else $error("write-back fields without write-back");

endmodule

bind lru_writeback_cache lwc_checker #(
  .KEY_BITS  (KEY_BITS),
  .DATA_BITS (DATA_BITS)
) u_lwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/sv/tb_lru_writeback_cache.sv @@
// ----------------------------------------------------------------------------
// tb_lru_writeback_cache
// self-checking bench for the fully associative lru write-back cache
// ----------------------------------------------------------------------------
// a directed table opens the run (empty cache, key and data extremes, fill on
// a hit, no-op words, out-of-range line limits, evictions of dirty lines),
// followed by random phases that each set a new line limit while the cache is
// idle. every accepted access word runs through a behavioral copy of the
// line array, and each result word is compared field by field against the
// oldest prediction. both sides idle at random; one phase holds the result
// side off long enough for the input to back up.
// ----------------------------------------------------------------------------
module tb_lru_writeback_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import lwc_pkg::*;

  localparam int NL = LINES_DEF;
  localparam int KW = KEY_BITS_DEF;
  localparam int DW = DATA_BITS_DEF;

  // cycles without any accepted word before the run is declared hung
  localparam int STUCK_LIMIT = 1000;
  // result-side hold-off used to back up the input channel
  localparam int LONG_HOLD   = 150;
  // non-no-op accesses per random phase
  localparam int PHASE_WORDS = 150;

  localparam logic [DW-1:0] ONES = '1;

  // one result word, unpacked from out_tuser / out_tdata
  typedef struct packed {
    logic          hit;
    logic [DW-1:0] rdata;
    logic          fetch;
    logic          wb;
    logic [KW-1:0] wb_key;
    logic [DW-1:0] wb_data;
  } cache_result_t;

  // directed step: either a limit write or an access, optionally with a
  // hand-written expectation
  typedef struct {
    bit            is_cfg;
    mode_t         op;
    logic [KW-1:0] k;
    logic [DW-1:0] d;
    bit            fixed;
    cache_result_t want;
  } dir_row_t;

  localparam cache_result_t R_NONE     = '0;
  localparam cache_result_t R_FETCH    = '{fetch: 1'b1, default: '0};
  localparam cache_result_t R_HIT      = '{hit: 1'b1, default: '0};
  localparam cache_result_t R_HIT_ONES = '{hit: 1'b1, rdata: '1, default: '0};
  // dirty victims of the limit-of-one steps below
  localparam cache_result_t R_WB_TOP   =
    '{wb: 1'b1, wb_key: '1, wb_data: '1, default: '0};
  localparam cache_result_t R_WB_LOW   =
    '{wb: 1'b1, wb_key: '0, wb_data: 64'h8000_0000_0000_0000, default: '0};

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             in_tvalid   = 1'b0;
  logic                             in_tready;
  // key, write_data
  logic [((KW+DW+7)/8)*8-1:0]       in_tdata    = '0;
  // mode
  logic [MODE_W-1:0]                in_tuser    = MODE_NOP;
  logic                             out_tvalid;
  logic                             out_tready  = 1'b0;
  // read_data, writeback_key, writeback_data
  logic [((2*DW+KW+7)/8)*8-1:0]     out_tdata;
  // hit, fetch_needed, writeback_valid
  logic [2:0]                       out_tuser;
  logic                             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]                 cfg_wr_data = '0;

  // predicted line array
  logic          line_ok    [NL];
  logic [KW-1:0] line_tag   [NL];
  logic [DW-1:0] line_word  [NL];
  logic          line_dirty [NL];
  logic [3:0]    line_age   [NL];
  logic [CFG_W-1:0] line_limit;

  cache_result_t awaited_results [$];
  int errors       = 0;
  int tx_max_gap   = 19;
  int rx_max_stall = 19;
  int hold_req     = 0;
  int quiet_cycles = 0;

  dir_row_t directed_rows [22] = '{
    // empty cache: reads at both key extremes miss
    '{1'b0, MODE_READ,  32'h0000_0000, 64'h0,                 1'b1, R_FETCH},
    '{1'b0, MODE_READ,  32'hFFFF_FFFF, 64'h0,                 1'b1, R_FETCH},
    // write miss inserts a dirty line, read hit returns it
    '{1'b0, MODE_WRITE, 32'hFFFF_FFFF, ONES,                  1'b1, R_NONE},
    '{1'b0, MODE_READ,  32'hFFFF_FFFF, 64'h0,                 1'b1, R_HIT_ONES},
    '{1'b0, MODE_FILL,  32'h0000_0000, 64'h0,                 1'b1, R_NONE},
    '{1'b0, MODE_READ,  32'h0000_0000, ONES,                  1'b1, R_HIT},
    // fill on a hit keeps the dirty cached word
    '{1'b0, MODE_FILL,  32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 1'b1, R_HIT},
    '{1'b0, MODE_READ,  32'hFFFF_FFFF, 64'h0,                 1'b1, R_HIT_ONES},
    // no-op words leave everything alone, even on a present key
    '{1'b0, MODE_NOP,   32'hDEAD_BEEF, ONES,                  1'b1, R_NONE},
    '{1'b0, MODE_NOP,   32'h0000_0000, ONES,                  1'b1, R_NONE},
    '{1'b0, MODE_WRITE, 32'h0000_0000, 64'h8000_0000_0000_0000, 1'b1, R_HIT},
    // limit zero behaves as one, with two lines already held
    '{1'b1, MODE_NOP,   32'h0,         64'd0,                 1'b0, R_NONE},
    '{1'b0, MODE_WRITE, 32'h0000_0055, 64'h5555_5555_5555_5555, 1'b1, R_WB_TOP},
    '{1'b0, MODE_FILL,  32'h0000_00AA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, R_WB_LOW},
    '{1'b0, MODE_READ,  32'h0000_0000, 64'h0,                 1'b1, R_FETCH},
    '{1'b0, MODE_READ,  32'h0000_0055, 64'h0,                 1'b0, R_NONE},
    '{1'b1, MODE_NOP,   32'h0,         64'd1,                 1'b0, R_NONE},
    '{1'b0, MODE_WRITE, 32'h1234_5678, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, R_NONE},
    // limit above the line count behaves as the full array
    '{1'b1, MODE_NOP,   32'h0,         64'd31,                1'b0, R_NONE},
    '{1'b0, MODE_FILL,  32'h8765_4321, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, R_NONE},
    '{1'b0, MODE_READ,  32'h0000_00AA, 64'h0,                 1'b0, R_NONE},
    '{1'b0, MODE_READ,  32'h1234_5678, 64'h0,                 1'b0, R_NONE}
  };

  lru_writeback_cache i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // behavioral line array: lookup, age update and insert with eviction for
  // one access word, returning the result word it must produce
  function automatic cache_result_t lru_access(mode_t op, logic [KW-1:0] k,
                                               logic [DW-1:0] d);
    cache_result_t res;
    int found, slot, used, cap, j;
    logic [3:0] a;
    res = '0;
    if (op == MODE_NOP) return res;
    found = -1;
    for (j = 0; j < NL; j++)
      if (found < 0 && line_ok[j] && line_tag[j] == k) found = j;
    if (found >= 0) begin
      res.hit = 1'b1;
      if (op == MODE_READ) begin
        res.rdata = line_word[found];
      end else if (op == MODE_WRITE) begin
        line_word[found]  = d;
        line_dirty[found] = 1'b1;
      end
      // fill on a hit only refreshes recency
      a = line_age[found];
      for (j = 0; j < NL; j++)
        if (line_ok[j] && line_age[j] < a) line_age[j]++;
      line_age[found] = '0;
    end else if (op == MODE_READ) begin
      res.fetch = 1'b1;
    end else begin
      // limit is clamped to 1 .. NL
      cap = (line_limit == 0) ? 1 : ((line_limit > NL) ? NL : int'(line_limit));
      used = 0;
      for (j = 0; j < NL; j++)
        if (line_ok[j]) used++;
      slot = -1;
      if (used >= cap) begin
        // one victim per insert, even when the limit was lowered below use
        for (j = 0; j < NL; j++)
          if (line_ok[j] && (slot < 0 || line_age[j] > line_age[slot])) slot = j;
        if (line_dirty[slot]) begin
          res.wb      = 1'b1;
          res.wb_key  = line_tag[slot];
          res.wb_data = line_word[slot];
        end
        line_ok[slot] = 1'b0;
      end else begin
        for (j = 0; j < NL; j++)
          if (slot < 0 && !line_ok[j]) slot = j;
      end
      for (j = 0; j < NL; j++)
        if (line_ok[j]) line_age[j]++;
      line_ok[slot]    = 1'b1;
      line_tag[slot]   = k;
      line_word[slot]  = d;
      line_dirty[slot] = (op == MODE_WRITE);
      line_age[slot]   = '0;
    end
    return res;
  endfunction

  function automatic void compare_field(string fname, logic [DW-1:0] want,
                                        logic [DW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endfunction

  // offer one access word after a random gap and record its prediction once
  // accepted; entered and left at a rising edge
  task automatic issue_access(input mode_t op, input logic [KW-1:0] k,
                              input logic [DW-1:0] d, input bit fixed,
                              input cache_result_t fixed_want,
                              output cache_result_t pred);
    int gap;
    gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {d, k};
    // ready is stable between edges, so decide the handshake at the falling edge
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    pred = lru_access(op, k, d);
    awaited_results.push_back(fixed ? fixed_want : pred);
  endtask

  // stop offering and let every outstanding result word drain
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write, only called while the cache is idle
  task automatic write_line_limit(input logic [CFG_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    line_limit  = v;
  endtask

  // result side: random stalls, one long hold-off on request, compare each
  // accepted result word with the oldest prediction
  initial begin : result_sink
    cache_result_t seen, want;
    int stall;
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = (rx_max_stall > 0) ? $urandom_range(0, rx_max_stall) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid && hold_req == 0) @(negedge clk);
      if (!out_tvalid) begin
        // hold-off requested while idle: start it at the next edge
        @(posedge clk);
        continue;
      end
      seen.hit     = out_tuser[0];
      seen.fetch   = out_tuser[1];
      seen.wb      = out_tuser[2];
      seen.rdata   = out_tdata[DW-1:0];
      seen.wb_key  = out_tdata[DW+KW-1:DW];
      seen.wb_data = out_tdata[2*DW+KW-1:DW+KW];
      @(posedge clk);
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, actual %h", $time, seen);
      end else begin
        want = awaited_results.pop_front();
        compare_field("hit",             DW'(want.hit),    DW'(seen.hit));
        compare_field("read_data",       want.rdata,       seen.rdata);
        compare_field("fetch_needed",    DW'(want.fetch),  DW'(seen.fetch));
        compare_field("writeback_valid", DW'(want.wb),     DW'(seen.wb));
        compare_field("writeback_key",   DW'(want.wb_key), DW'(seen.wb_key));
        compare_field("writeback_data",  want.wb_data,     seen.wb_data);
      end
    end
  end

  // watchdog: counts cycles in which no word moves on either channel
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_limits [12];
    logic [KW-1:0] key_pool [$];
    logic [KW-1:0] k;
    cache_result_t pred;
    int p, i, sent, eff, r;
    // small limits first so they matter before the array fills up
    phase_limits = '{5'd1, 5'd0, 5'd2, 5'd3, 5'd5, 5'd8, 5'd12, 5'd16,
                     5'd31, 5'd17, 5'd4, 5'd16};
    for (i = 0; i < NL; i++) begin
      line_ok[i]    = 1'b0;
      line_tag[i]   = '0;
      line_word[i]  = '0;
      line_dirty[i] = 1'b0;
      line_age[i]   = '0;
    end
    line_limit = CFG_ENTRIES_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_all_results();
        write_line_limit(directed_rows[i].d[CFG_W-1:0]);
      end else begin
        issue_access(directed_rows[i].op, directed_rows[i].k, directed_rows[i].d,
                     directed_rows[i].fixed, directed_rows[i].want, pred);
      end
    end

    // random phases, each under its own line limit
    for (p = 0; p < 12; p++) begin
      // sender pause until every result has come back
      wait_all_results();
      write_line_limit(phase_limits[p]);
      if (p % 4 == 1) begin
        // back to back on both sides
        tx_max_gap   = 0;
        rx_max_stall = 0;
      end else begin
        tx_max_gap   = 19;
        rx_max_stall = 19;
      end
      if (p == 3) begin
        // result side holds off while the sender keeps pushing
        tx_max_gap = 0;
        hold_req   = LONG_HOLD;
      end

      // key pool a little larger than the limit, so inserts evict
      eff = (phase_limits[p] == 0) ? 1 :
            ((phase_limits[p] > NL) ? NL : int'(phase_limits[p]));
      key_pool.delete();
      repeat (eff + $urandom_range(1, 6)) key_pool.push_back($urandom);

      sent = 0;
      while (sent < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 45) begin
          // read, and on a miss mostly follow with the fill of fetched data
          issue_access(MODE_READ, k, {$urandom, $urandom}, 1'b0, R_NONE, pred);
          sent++;
          if (pred.fetch && $urandom_range(0, 9) != 0) begin
            issue_access(MODE_FILL, k, {$urandom, $urandom}, 1'b0, R_NONE, pred);
            sent++;
          end
        end else if (r < 75) begin
          issue_access(MODE_WRITE, k, {$urandom, $urandom}, 1'b0, R_NONE, pred);
          sent++;
        end else if (r < 85) begin
          // fill without a preceding miss, hits keep the cached word
          issue_access(MODE_FILL, k, {$urandom, $urandom}, 1'b0, R_NONE, pred);
          sent++;
        end else if (r < 93) begin
          // stray key outside the pool
          issue_access(mode_t'($urandom_range(0, 2)), $urandom, {$urandom, $urandom},
                       1'b0, R_NONE, pred);
          sent++;
        end else begin
          issue_access(MODE_NOP, $urandom, {$urandom, $urandom}, 1'b0, R_NONE, pred);
        end
      end
    end

    wait_all_results();
    // leave room for any stray result word
    repeat (10) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
